// ===== src/bssl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bssl_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEPTH,
      ST_DIV,
      ST_RAMP,
      ST_MUL_A,
      ST_ADV,
      ST_MUL_B,
      ST_SMUL,
      ST_FINISH
   } state_type;

   localparam logic [2:0] CSR_LOCKED_MODE  = 3'd0;
   localparam logic [2:0] CSR_RATE         = 3'd1;
   localparam logic [2:0] CSR_FREE_STEP    = 3'd2;
   localparam logic [2:0] CSR_DEPTH_TARGET = 3'd3;
   localparam logic [2:0] CSR_RAMP_SAMPLES = 3'd4;

   localparam logic [15:0] DEPTH_TARGET_RST = 16'd32768;
   localparam logic [14:0] RATE_RST         = 15'd1024;
   localparam logic [31:0] FREE_STEP_RST    = 32'd22370;
   localparam logic [15:0] RAMP_SAMPLES_RST = 16'd240;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;
   localparam longint unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

   // quarter-wave sine entry, Taylor series in Q2.30, scaled to the sample amplitude
   function automatic longint unsigned quarter_sine(input int r, input int tab_bits,
                                                    input int smp_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned amp;
      longint unsigned s;
      x   = (longint'(r) * HALF_PI_Q30) >> (tab_bits - 2);
      x2  = (x * x) >> 30;
      t   = ONE_Q30;
      amp = (64'd1 << (smp_bits - 1)) - 64'd1;
      for (int i = 0; i < 6; i++) begin
         t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[i];
      end
      s = (x * t) >> 30;
      return (s * amp + (ONE_Q30 >> 1)) >> 30;
   endfunction

endpackage
`default_nettype wire

// ===== src/beat_synced_sine_lfo.sv =====
// One request at a time: req_stall is high from accept until the result is registered at
// the output. The shared bit-serial multiplier (twice per sample), the sine-by-depth shift-add
// and, on a ramped depth target change, the restoring divider for the ramp increment run in turn.
// Reset: synchronous, active high; CSR, phase, beat and depth registers take defaults, depth 1.0.
`timescale 1ns / 1ps
`default_nettype none
module beat_synced_sine_lfo #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_block_start,
   input  wire signed  [63:0] req_block_beat,
   input  wire         [31:0] req_beat_step,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [15:0] rsp_cv_sample,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire          [2:0] csr_index,
   input  wire         [31:0] csr_data
);

   localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
   localparam int AW      = SINE_TABLE_BITS - 1;
   localparam int VW      = SAMPLE_BITS - 1;
   localparam int PW      = VW + 32;
   localparam int SH      = SAMPLE_BITS + 15;
   localparam int MW      = PW + 1 - SH;
   localparam logic [5:0] MUL_LAST  = 6'd14;
   localparam logic [5:0] DIV_LAST  = 6'd32;
   localparam logic [5:0] SMUL_LAST = 6'(VW - 1);
   localparam logic [AW-1:0] QADDR  = AW'(QUARTER);

   logic [VW-1:0] qtab [0:QUARTER];
   for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
      localparam logic [VW-1:0] QV = VW'(bssl_pkg::quarter_sine(g, SINE_TABLE_BITS,
                                                               SAMPLE_BITS));
      assign qtab[g] = QV;
   end

   bssl_pkg::state_type state_ff, state_in;

   logic        locked_ff;
   logic [14:0] rate_ff;
   logic [31:0] free_step_ff;
   logic [15:0] depth_target_ff;
   logic [15:0] ramp_samples_ff;

   logic [31:0] phase_ff;
   logic [63:0] beat_ff;
   logic [31:0] step_ff;
   logic [31:0] depth_now_ff;
   logic [31:0] depth_inc_ff;
   logic [15:0] ramp_left_ff;
   logic [15:0] goal_seen_ff;

   logic [5:0]  cnt_ff;
   logic [43:0] mul_acc_ff;
   logic [43:0] mul_a_ff;
   logic [14:0] mul_b_ff;
   logic [15:0] div_rem_ff;
   logic [32:0] div_dvd_ff;
   logic [15:0] div_den_ff;
   logic        div_neg_ff;
   logic [AW-1:0] rom_addr_ff;
   logic [VW-1:0] rom_q_ff;
   logic        sine_neg_ff;
   logic [PW-1:0] sm_acc_ff;
   logic [PW-1:0] sm_a_ff;
   logic [VW-1:0] sm_b_ff;
   logic        rsp_valid_ff;
   logic signed [15:0] rsp_cv_ff;

   logic [43:0] mul_acc_nx;
   logic [16:0] rem_sh;
   logic        rem_ge;
   logic [32:0] dvd_nx;
   logic [15:0] rem_nx;
   logic [32:0] diff;
   logic [32:0] diff_mag;
   logic [31:0] goal_new;
   logic [31:0] goal_seen_q;
   logic [15:0] ramp_dec;
   logic [31:0] ph_sel;
   logic [SINE_TABLE_BITS-1:0] ph_idx;
   logic [AW-1:0] ph_r;
   logic [63:0] beat_adv;
   logic [PW:0] round_sum;
   logic [MW-1:0] mag;
   logic signed [15:0] cv;
   logic        accept;
   logic        out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != bssl_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_cv_sample = rsp_cv_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign mul_acc_nx = mul_acc_ff + (mul_b_ff[0] ? mul_a_ff : 44'd0);
   assign rem_sh     = {div_rem_ff, div_dvd_ff[32]};
   assign rem_ge     = rem_sh >= {1'b0, div_den_ff};
   assign rem_nx     = rem_ge ? 16'(rem_sh - {1'b0, div_den_ff}) : rem_sh[15:0];
   assign dvd_nx     = {div_dvd_ff[31:0], rem_ge};
   assign goal_new   = {depth_target_ff, 16'd0};
   assign goal_seen_q = {goal_seen_ff, 16'd0};
   assign diff       = {1'b0, goal_new} - {1'b0, depth_now_ff};
   assign diff_mag   = diff[32] ? (33'd0 - diff) : diff;
   assign ramp_dec   = ramp_left_ff - 16'd1;
   assign ph_sel     = locked_ff ? mul_acc_nx[43:12] : phase_ff;
   assign ph_idx     = ph_sel[31 -: SINE_TABLE_BITS];
   assign ph_r       = {1'b0, ph_idx[SINE_TABLE_BITS-3:0]};
   assign beat_adv   = beat_ff + {32'd0, step_ff};
   assign round_sum  = {1'b0, sm_acc_ff} + ((PW+1)'(1) << (SH - 1));
   assign mag        = MW'(round_sum >> SH);

   always_comb begin
      if (sine_neg_ff) begin
         cv = (mag > MW'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, mag}));
      end else begin
         cv = (mag > MW'(32767)) ? 16'sd32767 : $signed(mag[15:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bssl_pkg::ST_IDLE:   if (accept) state_in = bssl_pkg::ST_DEPTH;
         bssl_pkg::ST_DEPTH: begin
            if (depth_target_ff != goal_seen_ff && ramp_samples_ff != 16'd0) begin
               state_in = bssl_pkg::ST_DIV;
            end else begin
               state_in = bssl_pkg::ST_RAMP;
            end
         end
         bssl_pkg::ST_DIV:    if (cnt_ff == DIV_LAST) state_in = bssl_pkg::ST_RAMP;
         bssl_pkg::ST_RAMP:   state_in = bssl_pkg::ST_MUL_A;
         bssl_pkg::ST_MUL_A:  if (cnt_ff == MUL_LAST) state_in = bssl_pkg::ST_ADV;
         bssl_pkg::ST_ADV:    state_in = bssl_pkg::ST_MUL_B;
         bssl_pkg::ST_MUL_B:  if (cnt_ff == MUL_LAST) state_in = bssl_pkg::ST_SMUL;
         bssl_pkg::ST_SMUL:   if (cnt_ff == SMUL_LAST) state_in = bssl_pkg::ST_FINISH;
         bssl_pkg::ST_FINISH: if (out_free) state_in = bssl_pkg::ST_IDLE;
         default:             state_in = bssl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bssl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff       <= 1'b0;
         rate_ff         <= bssl_pkg::RATE_RST;
         free_step_ff    <= bssl_pkg::FREE_STEP_RST;
         depth_target_ff <= bssl_pkg::DEPTH_TARGET_RST;
         ramp_samples_ff <= bssl_pkg::RAMP_SAMPLES_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bssl_pkg::CSR_LOCKED_MODE:  locked_ff       <= csr_data[0];
            bssl_pkg::CSR_RATE:         rate_ff         <= csr_data[14:0];
            bssl_pkg::CSR_FREE_STEP:    free_step_ff    <= csr_data;
            bssl_pkg::CSR_DEPTH_TARGET: depth_target_ff <= csr_data[15:0];
            bssl_pkg::CSR_RAMP_SAMPLES: ramp_samples_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= qtab[rom_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 32'd0;
         beat_ff      <= 64'd0;
         depth_now_ff <= {bssl_pkg::DEPTH_TARGET_RST, 16'd0};
         depth_inc_ff <= 32'd0;
         ramp_left_ff <= 16'd0;
         goal_seen_ff <= bssl_pkg::DEPTH_TARGET_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != bssl_pkg::ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            bssl_pkg::ST_IDLE: begin
               if (accept) begin
                  if (req_block_start) beat_ff <= req_block_beat;
                  step_ff <= req_beat_step;
               end
            end
            bssl_pkg::ST_DEPTH: begin
               cnt_ff <= 6'd0;
               if (depth_target_ff != goal_seen_ff) begin
                  goal_seen_ff <= depth_target_ff;
                  if (ramp_samples_ff == 16'd0) begin
                     depth_now_ff <= goal_new;
                     ramp_left_ff <= 16'd0;
                  end else begin
                     ramp_left_ff <= ramp_samples_ff;
                     div_rem_ff   <= 16'd0;
                     div_dvd_ff   <= diff_mag;
                     div_den_ff   <= ramp_samples_ff;
                     div_neg_ff   <= diff[32];
                  end
               end
            end
            bssl_pkg::ST_DIV: begin
               cnt_ff     <= cnt_ff + 6'd1;
               div_rem_ff <= rem_nx;
               div_dvd_ff <= dvd_nx;
               if (cnt_ff == DIV_LAST) begin
                  depth_inc_ff <= div_neg_ff ? 32'(33'd0 - dvd_nx) : dvd_nx[31:0];
               end
            end
            bssl_pkg::ST_RAMP: begin
               if (ramp_left_ff == 16'd0) begin
                  depth_now_ff <= goal_seen_q;
               end else begin
                  ramp_left_ff <= ramp_dec;
                  depth_now_ff <= (ramp_dec == 16'd0) ? goal_seen_q
                                                      : depth_now_ff + depth_inc_ff;
               end
               cnt_ff     <= 6'd0;
               mul_acc_ff <= 44'd0;
               mul_a_ff   <= beat_ff[43:0];
               mul_b_ff   <= rate_ff;
            end
            bssl_pkg::ST_MUL_A, bssl_pkg::ST_MUL_B: begin
               mul_acc_ff <= mul_acc_nx;
               mul_a_ff   <= {mul_a_ff[42:0], 1'b0};
               mul_b_ff   <= {1'b0, mul_b_ff[14:1]};
               if (cnt_ff == MUL_LAST) begin
                  cnt_ff <= 6'd0;
                  if (state_ff == bssl_pkg::ST_MUL_A) begin
                     rom_addr_ff <= ph_idx[SINE_TABLE_BITS-2] ? QADDR - ph_r : ph_r;
                     sine_neg_ff <= ph_idx[SINE_TABLE_BITS-1];
                  end else begin
                     phase_ff  <= locked_ff ? mul_acc_nx[43:12] : phase_ff + free_step_ff;
                     sm_acc_ff <= '0;
                     sm_a_ff   <= PW'(depth_now_ff);
                     sm_b_ff   <= rom_q_ff;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            bssl_pkg::ST_ADV: begin
               beat_ff    <= beat_adv;
               cnt_ff     <= 6'd0;
               mul_acc_ff <= 44'd0;
               mul_a_ff   <= beat_adv[43:0];
               mul_b_ff   <= rate_ff;
            end
            bssl_pkg::ST_SMUL: begin
               cnt_ff    <= cnt_ff + 6'd1;
               sm_acc_ff <= sm_acc_ff + (sm_b_ff[0] ? sm_a_ff : '0);
               sm_a_ff   <= {sm_a_ff[PW-2:0], 1'b0};
               sm_b_ff   <= sm_b_ff >> 1;
            end
            bssl_pkg::ST_FINISH: begin
               if (out_free) begin
                  rsp_cv_ff    <= cv;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== src/bssl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bssl_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input wire signed [15:0] rsp_cv_sample
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held off after a transaction");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_cv_sample))
      else $error("stalled result changed");

endmodule

bind beat_synced_sine_lfo bssl_checker u_bssl_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_cv_sample(rsp_cv_sample)
);
`default_nettype wire

// ===== bench/tb_beat_synced_sine_lfo.sv =====
`timescale 1ns / 1ps
module tb_beat_synced_sine_lfo;

   localparam int TAB_BITS  = 10;
   localparam int SMP_BITS  = 16;
   localparam int WD_LIMIT  = 5000;
   localparam int N_DIRECT  = 12;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_block_start = 1'b0;
   logic signed [63:0] req_block_beat = '0;
   logic        [31:0] req_beat_step = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_cv_sample;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic         [2:0] csr_index = '0;
   logic        [31:0] csr_data = '0;

   beat_synced_sine_lfo dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_block_start(req_block_start), .req_block_beat(req_block_beat),
      .req_beat_step(req_beat_step),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cv_sample(rsp_cv_sample),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // predictor state
   logic signed [15:0] sine_lut [1 << TAB_BITS];
   bit          [0:0]  m_locked;
   bit         [14:0]  m_rate;
   bit         [31:0]  m_free_step;
   bit         [15:0]  m_depth_target;
   bit         [15:0]  m_ramp;
   bit         [31:0]  m_phase;
   bit         [63:0]  m_beat_pos;
   bit         [31:0]  m_depth;
   bit         [31:0]  m_depth_inc;
   bit         [15:0]  m_ramp_left;
   bit         [15:0]  m_goal_seen;

   logic [15:0] cv_expected [$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   bit          hold_request = 0;
   int          hold_count = 0;
   int          stall_mode = 0;
   int          mode_left = 0;

   bit          d_start [N_DIRECT] = '{1, 0, 1, 0, 1, 1, 0, 1, 1, 0, 1, 0};
   logic [63:0] d_beat  [N_DIRECT] = '{64'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0,
      64'h8000_0000_0000_0000, 64'hFFFF_FFFF_8000_0000, 64'd0, 64'h0000_0001_4000_0000,
      64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'h0000_0000_C000_0000, 64'd0};
   logic [31:0] d_step  [N_DIRECT] = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
      32'd1, 32'h4000_0000, 32'h8000_0000, 32'd178957, 32'hFFFF_FFFF, 32'd0,
      32'h2000_0000, 32'h1234_5678};

   function automatic logic signed [15:0] quarter_wave(int unsigned r);
      longint unsigned x, x2, t, s, amp;
      longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
      x   = (longint'(r) * 64'd1686629713) >> (TAB_BITS - 2);
      x2  = (x * x) >> 30;
      t   = 64'd1 << 30;
      amp = (64'd1 << (SMP_BITS - 1)) - 1;
      for (int i = 0; i < 6; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
      s = (x * t) >> 30;
      return 16'((s * amp + (64'd1 << 29)) >> 30);
   endfunction

   function automatic void model_reset();
      int unsigned quarter, q, r;
      logic signed [15:0] v;
      quarter = 1 << (TAB_BITS - 2);
      for (int k = 0; k < (1 << TAB_BITS); k++) begin
         q = k >> (TAB_BITS - 2);
         r = k & (quarter - 1);
         v = q[0] ? quarter_wave(quarter - r) : quarter_wave(r);
         sine_lut[k] = q[1] ? -v : v;
      end
      m_locked = 0; m_rate = 1024; m_free_step = 22370;
      m_depth_target = 32768; m_ramp = 240;
      m_phase = 0; m_beat_pos = 0; m_depth = 32'd32768 << 16;
      m_depth_inc = 0; m_ramp_left = 0; m_goal_seen = 32768;
   endfunction

   function automatic void model_write(logic [2:0] idx, logic [31:0] val);
      case (idx)
         bssl_pkg::CSR_LOCKED_MODE:  m_locked = val[0];
         bssl_pkg::CSR_RATE:         m_rate = val[14:0];
         bssl_pkg::CSR_FREE_STEP:    m_free_step = val;
         bssl_pkg::CSR_DEPTH_TARGET: m_depth_target = val[15:0];
         bssl_pkg::CSR_RAMP_SAMPLES: m_ramp = val[15:0];
         default: ;
      endcase
   endfunction

   function automatic logic [15:0] lfo_sample(bit start, logic [63:0] beat,
                                              logic [31:0] step);
      bit [31:0] goal, ph;
      longint diff, inc;
      bit [63:0] prod;
      longint signed sine;
      longint unsigned mag;
      if (start) m_beat_pos = beat;
      if (m_depth_target != m_goal_seen) begin
         m_goal_seen = m_depth_target;
         goal = {m_goal_seen, 16'h0};
         if (m_ramp == 0) begin
            m_depth = goal;
            m_ramp_left = 0;
         end else begin
            diff = longint'({32'h0, goal}) - longint'({32'h0, m_depth});
            inc = diff / longint'({48'h0, m_ramp});
            m_depth_inc = inc[31:0];
            m_ramp_left = m_ramp;
         end
      end
      goal = {m_goal_seen, 16'h0};
      if (m_ramp_left == 0) begin
         m_depth = goal;
      end else begin
         m_ramp_left--;
         if (m_ramp_left == 0) m_depth = goal;
         else m_depth += m_depth_inc;
      end
      prod = m_beat_pos * {49'h0, m_rate};
      ph = m_locked ? prod[43:12] : m_phase;
      sine = sine_lut[ph[31:32-TAB_BITS]];
      m_beat_pos += {32'h0, step};
      prod = m_beat_pos * {49'h0, m_rate};
      if (m_locked) m_phase = prod[43:12];
      else m_phase += m_free_step;
      mag = longint'(sine < 0 ? -sine : sine) * {32'h0, m_depth};
      mag = (mag + (64'd1 << 30)) >> 31;
      if (sine < 0) return (mag > 32768) ? 16'h8000 : 16'(-longint'(mag));
      return (mag > 32767) ? 16'h7FFF : 16'(mag);
   endfunction

   task automatic report_mismatch(logic [15:0] got, logic [15:0] want);
      $display("cv_sample mismatch: got %0d expected %0d at %0t",
               $signed(got), $signed(want), $realtime);
      errors++;
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      model_write(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(bit lk, logic [14:0] rt, logic [31:0] fs,
                                logic [15:0] dt, logic [15:0] rs);
      csr_write(bssl_pkg::CSR_LOCKED_MODE, {31'h0, lk});
      csr_write(bssl_pkg::CSR_RATE, {17'h0, rt});
      csr_write(bssl_pkg::CSR_FREE_STEP, fs);
      csr_write(bssl_pkg::CSR_DEPTH_TARGET, {16'h0, dt});
      csr_write(bssl_pkg::CSR_RAMP_SAMPLES, {16'h0, rs});
   endtask

   task automatic send_txn(bit start, logic [63:0] beat, logic [31:0] step,
                           bit typed, logic [15:0] typed_cv);
      int gap;
      logic [15:0] cv;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_block_start <= start;
      req_block_beat  <= beat;
      req_beat_step   <= step;
      do @(posedge clock); while (req_stall);
      cv = lfo_sample(start, beat, step);
      cv_expected.push_back(typed ? typed_cv : cv);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (cv_expected.size() != 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic random_txn();
      logic [31:0] step;
      case ($urandom_range(0, 3))
         0: step = $urandom;
         1: step = $urandom_range(0, 1 << 20);
         2: step = 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: step = $urandom_range(100000, 400000);
      endcase
      send_txn($urandom_range(0, 7) == 0, {$urandom, $urandom}, step, 0, '0);
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_count = 400;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_count > 0) begin
         hold_count--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cv_expected.size() == 0) begin
            $display("unexpected cv_sample transaction %0d at %0t", rsp_cv_sample, $realtime);
            errors++;
         end else begin
            if (rsp_cv_sample !== cv_expected[0])
               report_mismatch(rsp_cv_sample, cv_expected[0]);
            void'(cv_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("[beat_synced_sine_lfo] ERROR");
         $finish;
      end
   end

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECT; i++)
         send_txn(d_start[i], d_beat[i], d_step[i], i == 0, 16'd0);
      drain();
      apply_setting(1, 15'd16384, 32'd0, 16'd32768, 16'd0);
      csr_write(3'd5, $urandom);
      csr_write(3'd7, $urandom);
      for (int i = 0; i < N_DIRECT; i++)
         send_txn(d_start[i], d_beat[i], d_step[i], 0, '0);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: apply_setting(1, 15'd256, 32'hFFFF_FFFF, 16'd0, 16'd1);
            1: apply_setting(0, 15'h7FFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
            2: apply_setting(1, 15'd0, $urandom, 16'd16384, 16'hFFFF);
            3: apply_setting(0, 15'd1024, 32'd22370, 16'd32768, 16'd240);
            4: apply_setting(1, 15'd16384, $urandom, 16'hFFFF, 16'd30);
            default: apply_setting(1'($urandom_range(0, 1)), 15'($urandom), $urandom,
                                   16'($urandom), 16'($urandom_range(0, 300)));
         endcase
         if (ph == 3) hold_request = 1;
         for (int n = 0; n < 82; n++) begin
            if (n == 40 && ph >= 5) begin
               drain();
               csr_write(bssl_pkg::CSR_RAMP_SAMPLES, $urandom_range(0, 50));
            end
            random_txn();
         end
         drain();
         csr_write(bssl_pkg::CSR_DEPTH_TARGET, $urandom_range(0, 40000));
      end
      drain();
      if (errors == 0)
         $display("[beat_synced_sine_lfo] OK");
      else
         $display("[beat_synced_sine_lfo] ERROR");
      $finish;
   end

endmodule
